FILE: sv/cas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_pkg: shared types and constants of the CPU clock and stepper
// Register indexes, reset values, divider widths and the control structs
// that run between the sequencer, the divider and the stepper.
// ----------------------------------------------------------------------------
package cas_pkg;

	localparam int TIMER_BITS_DEF = 16;

	// Shared divider: 10-bit dividend, 12-bit divisor.
	localparam int NUM_W = 10;
	localparam int DEN_W = 12;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam int HZ_W       = 10;
	localparam int SLOWDOWN_W = 8;
	localparam int DEBOUNCE_W = 16;
	localparam int STEP_W     = 3;
	localparam int QCOUNT_W   = 32;
	localparam int BITS_W     = 8;

	localparam logic [NUM_W-1:0]      MS_PER_SECOND  = NUM_W'(1000);
	localparam logic [HZ_W-1:0]       CLOCK_HZ_RST   = HZ_W'(1);
	localparam logic [SLOWDOWN_W-1:0] SLOWDOWN_RST   = SLOWDOWN_W'(1);
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST   = DEBOUNCE_W'(50);
	localparam logic [STEP_W-1:0]     STEP_LAST      = STEP_W'(6);
	localparam logic [STEP_W-1:0]     STEP_FIRST     = STEP_W'(1);
	localparam logic [1:0]            PHASE_SET      = 2'd1;
	localparam logic [1:0]            PHASE_IDLE     = 2'd3;
	localparam logic [1:0]            PHASE_STEP     = 2'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MANUAL_MODE = 2'd0,
		REG_CLOCK_HZ    = 2'd1,
		REG_SLOWDOWN    = 2'd2,
		REG_DEBOUNCE_MS = 2'd3
	} reg_index_t;

	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic advance;
		logic restart;
	} step_ctl_t;

endpackage

FILE: sv/cas_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_if: item and result channels of the CPU clock and stepper
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface cas_item_if;
	logic valid;
	logic ready;
	logic op;
	logic button_level;

	modport source (output valid, output op, output button_level, input ready);
	modport sink (input valid, input op, input button_level, output ready);
endinterface

interface cas_result_if;
	logic              valid;
	logic              ready;
	logic [7:0]        clock_bits;
	logic              new_bits;
	logic              waiting;
	logic signed [31:0] quarter_ticks;

	modport source (output valid, output clock_bits, output new_bits, output waiting,
		output quarter_ticks, input ready);
	modport sink (input valid, input clock_bits, input new_bits, input waiting,
		input quarter_ticks, output ready);
endinterface

FILE: sv/cas_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_div: shared restoring divider
// One quotient bit per cycle; done is high for a single cycle, registered together with the last bit.
// ----------------------------------------------------------------------------
module cas_div (
	input  logic              clk,
	input  logic              arst_n,
	input  cas_pkg::div_req_t req,
	output cas_pkg::div_rsp_t rsp
);

	localparam int NW  = cas_pkg::NUM_W;
	localparam int DW  = cas_pkg::DEN_W;
	localparam int CNW = $clog2(NW + 1);

	logic [DW-1:0]  rem_q;
	logic [NW-1:0]  quo_q;
	logic [DW-1:0]  den_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [DW:0] shifted;
	logic [DW:0] diff;
	logic        fits;

	always_comb begin
		shifted = {rem_q, quo_q[NW-1]};
		diff    = shifted - {1'b0, den_q};
		fits    = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNW'(1);
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder always stays below the divisor, so DW bits hold it.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

FILE: sv/cas_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_step: four-phase clock and six-step stepper
// Holds the quarter tick count, the step number and the last output pattern.
// ----------------------------------------------------------------------------
module cas_step (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cas_pkg::step_ctl_t                  ctl,
	output logic [cas_pkg::BITS_W-1:0]          bits,
	output logic [cas_pkg::QCOUNT_W-1:0]        qcount
);

	logic [cas_pkg::QCOUNT_W-1:0] qcount_q;
	logic [cas_pkg::STEP_W-1:0]   step_q;
	logic [cas_pkg::BITS_W-1:0]   bits_q;

	logic [cas_pkg::QCOUNT_W-1:0] qcount_d;
	logic [1:0]                   phase;
	logic [cas_pkg::STEP_W-1:0]   step_d;
	logic [5:0]                   step_hot;

	always_comb begin
		qcount_d = qcount_q + cas_pkg::QCOUNT_W'(1);
		phase    = qcount_d[1:0];
		step_d   = step_q;
		if (phase == cas_pkg::PHASE_STEP) begin
			step_d = (step_q >= cas_pkg::STEP_LAST) ? cas_pkg::STEP_FIRST
				: step_q + cas_pkg::STEP_W'(1);
		end
		// Step 1 lights bit 7, step 6 lights bit 2.
		step_hot = '0;
		if (step_d >= cas_pkg::STEP_FIRST && step_d <= cas_pkg::STEP_LAST) begin
			step_hot = 6'b100000 >> (step_d - cas_pkg::STEP_FIRST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcount_q <= '1;
			step_q   <= '0;
			bits_q   <= '0;
		end else if (ctl.restart) begin
			qcount_q <= '1;
			step_q   <= '0;
		end else if (ctl.advance) begin
			qcount_q <= qcount_d;
			step_q   <= step_d;
			bits_q   <= {step_hot, phase != cas_pkg::PHASE_IDLE, phase == cas_pkg::PHASE_SET};
		end
	end

	assign bits   = bits_q;
	assign qcount = qcount_q;

endmodule

FILE: sv/cpu_clock_and_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_clock_and_stepper: clock and stepper generator for a teaching CPU
// Turns millisecond ticks and restarts into four-phase clock patterns.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the item channel is either a one millisecond tick that
// carries the raw level of the manual clock button, or a restart. Every item
// yields exactly one transaction on the result channel: the current clock
// pattern, whether a quarter tick fired, the waiting lamp and the quarter tick
// count since restart minus one.
// Configuration registers (manual mode, clock frequency, slowdown, debounce
// time) are written through the plain write port; the user must write them
// only while no item is in flight, as the block itself does not enforce it.
// The automatic period is found with two divisions on one shared restoring
// divider, one quotient bit per cycle: clock_hz / slowdown, then 1000 /
// (4 * rate). The block takes one item at a time and accepts the next one
// only after the previous result has been offered.
// A result waits in the output register while the receiver stalls; the next
// item is still accepted and computed, but its state update is held until
// the waiting result has been taken.
// After reset the block is in automatic mode with the waiting lamp on, the
// quarter count all ones and the output pattern zero; it is ready at once.
// ----------------------------------------------------------------------------
module cpu_clock_and_stepper #(
	parameter int TIMER_BITS = cas_pkg::TIMER_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	cas_item_if.sink                           item,
	cas_result_if.source                       result,
	input  logic                               cfg_wr_en,
	input  logic [cas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cas_pkg::CFG_W-1:0]          cfg_data
);

	localparam int CMP_W = (TIMER_BITS > cas_pkg::DEBOUNCE_W) ? TIMER_BITS
		: cas_pkg::DEBOUNCE_W;
	localparam int THR_W = (TIMER_BITS > cas_pkg::NUM_W) ? TIMER_BITS : cas_pkg::NUM_W;

	// One-hot sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV1 = 4'b0010,
		ST_DIV2 = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic                              manual_q;
	logic [cas_pkg::HZ_W-1:0]          clock_hz_q;
	logic [cas_pkg::SLOWDOWN_W-1:0]    slowdown_q;
	logic [cas_pkg::DEBOUNCE_W-1:0]    debounce_q;

	// Captured item.
	logic op_q;
	logic level_q;

	// Clock state.
	logic                  started_q;
	logic [TIMER_BITS-1:0] elapsed_q;
	logic                  stable_q;
	logic                  previous_q;
	logic [TIMER_BITS-1:0] since_q;
	logic                  waiting_q;
	logic                  div_ok_q;

	// Result register.
	logic out_valid_q;
	logic new_bits_q;

	cas_pkg::div_req_t  div_req;
	cas_pkg::div_rsp_t  div_rsp;
	cas_pkg::step_ctl_t step_ctl;

	logic [cas_pkg::BITS_W-1:0]   step_bits;
	logic [cas_pkg::QCOUNT_W-1:0] step_qcount;

	logic                        go;
	logic [cas_pkg::NUM_W-1:0]   rate;
	logic [cas_pkg::DEN_W-1:0]   period_div;
	logic [TIMER_BITS-1:0]       elapsed_inc;
	logic [TIMER_BITS-1:0]       since_inc;
	logic [TIMER_BITS-1:0]       since_now;
	logic                        press;
	logic                        fire;
	logic                        started_d;
	logic [TIMER_BITS-1:0]       elapsed_d;
	logic                        stable_d;
	logic                        previous_d;
	logic [TIMER_BITS-1:0]       since_d;
	logic                        waiting_d;

	cas_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	cas_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (step_ctl),
		.bits   (step_bits),
		.qcount (step_qcount)
	);

	// The state update of an item is applied only once the previous result
	// has left the output register, so the stepper registers can feed the
	// result channel directly.
	assign go = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	// A zero slowdown, or a frequency below the slowdown, stops the automatic clock.
	assign rate       = (slowdown_q == '0) ? '0 : div_rsp.quo;
	assign period_div = {rate, 2'b00};

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = clock_hz_q;
		div_req.den   = cas_pkg::DEN_W'(slowdown_q);
		if (state_q == ST_IDLE && item.valid) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_DIV1) begin
			div_req.start = div_rsp.done;
			div_req.num   = cas_pkg::MS_PER_SECOND;
			div_req.den   = period_div;
		end
	end

	// Next clock state for the captured item.
	always_comb begin
		elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TIMER_BITS'(1);
		since_inc   = (since_q == '1) ? since_q : since_q + TIMER_BITS'(1);
		since_now   = (level_q != previous_q) ? '0 : since_inc;
		press       = (CMP_W'(since_now) > CMP_W'(debounce_q)) && (level_q != stable_q);

		started_d  = started_q;
		elapsed_d  = elapsed_q;
		stable_d   = stable_q;
		previous_d = previous_q;
		since_d    = since_q;
		waiting_d  = waiting_q;
		fire       = 1'b0;

		if (op_q == cas_pkg::OP_RESTART) begin
			started_d  = 1'b0;
			elapsed_d  = '0;
			stable_d   = manual_q;
			previous_d = manual_q;
			waiting_d  = 1'b1;
		end else if (!manual_q) begin
			since_d = since_inc;
			if (!started_q) begin
				// The first tick after a restart only turns the lamp off.
				started_d = 1'b1;
				waiting_d = 1'b0;
				elapsed_d = elapsed_inc;
			end else begin
				fire      = div_ok_q
					&& (THR_W'(elapsed_inc) >= THR_W'(div_rsp.quo));
				elapsed_d = fire ? '0 : elapsed_inc;
			end
		end else begin
			elapsed_d  = elapsed_inc;
			since_d    = since_now;
			previous_d = level_q;
			if (press) begin
				stable_d = level_q;
			end
			fire = press && level_q;
		end
	end

	assign step_ctl.restart = go && (op_q == cas_pkg::OP_RESTART);
	assign step_ctl.advance = go && fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			manual_q    <= 1'b0;
			clock_hz_q  <= cas_pkg::CLOCK_HZ_RST;
			slowdown_q  <= cas_pkg::SLOWDOWN_RST;
			debounce_q  <= cas_pkg::DEBOUNCE_RST;
			started_q   <= 1'b0;
			elapsed_q   <= '0;
			stable_q    <= 1'b0;
			previous_q  <= 1'b0;
			since_q     <= '0;
			waiting_q   <= 1'b1;
			div_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
			new_bits_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cas_pkg::reg_index_t'(cfg_index))
					cas_pkg::REG_MANUAL_MODE: manual_q   <= cfg_data[0];
					cas_pkg::REG_CLOCK_HZ:    clock_hz_q <= cfg_data[cas_pkg::HZ_W-1:0];
					cas_pkg::REG_SLOWDOWN:    slowdown_q <= cfg_data[cas_pkg::SLOWDOWN_W-1:0];
					cas_pkg::REG_DEBOUNCE_MS: debounce_q <= cfg_data;
				endcase
			end

			// A new result loaded in the same cycle keeps the register full.
			if (result.valid && result.ready && !go) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						div_ok_q <= (period_div != '0);
						state_q  <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_rsp.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (go) begin
						started_q   <= started_d;
						elapsed_q   <= elapsed_d;
						stable_q    <= stable_d;
						previous_q  <= previous_d;
						since_q     <= since_d;
						waiting_q   <= waiting_d;
						new_bits_q  <= fire;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_q    <= item.op;
			level_q <= item.button_level;
		end
	end

	assign item.ready           = (state_q == ST_IDLE);
	assign result.valid         = out_valid_q;
	assign result.clock_bits    = step_bits;
	assign result.new_bits      = new_bits_q;
	assign result.waiting       = waiting_q;
	assign result.quarter_ticks = $signed(step_qcount);

endmodule

FILE: sv/cas_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_chk: port checker for the CPU clock and stepper
// Watches the item and result channels and the shape of the clock pattern.
// ----------------------------------------------------------------------------
module cas_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [7:0]        clock_bits,
	input logic              new_bits,
	input logic [31:0]       quarter_ticks
);

	// A pending result is not withdrawn.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// One item at a time: the item channel closes right after a transaction.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item channel stayed open after a transaction");

	// At most one step lamp is lit.
	a_step_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(clock_bits[7:2]))
		else $error("more than one step bit set");

	// A fresh pattern matches the phase given by the quarter tick count.
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_bits |->
			(clock_bits[1] == (quarter_ticks[1:0] != 2'd3))
			&& (clock_bits[0] == (quarter_ticks[1:0] == 2'd1)))
		else $error("enable/set bits disagree with the phase");

endmodule

bind cpu_clock_and_stepper cas_chk u_cas_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (item.valid),
	.in_ready      (item.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.clock_bits    (result.clock_bits),
	.new_bits      (result.new_bits),
	.quarter_ticks (result.quarter_ticks)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the CPU clock and stepper
// Drives millisecond ticks and restarts into the block under several register
// settings and keeps a cycle-free model of the clock and stepper alongside it.
// Every result transaction is compared field by field with the model's answer
// for the oldest item still waiting, while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int TIMER_W       = cas_pkg::TIMER_BITS_DEF;
	// The settle time covers an item's passage through the block with room to
	// spare before registers change or the run ends.
	localparam int SETTLE_CYCLES = 40;
	// The limit lies well above the length of the slowest correct run, so only
	// a hung handshake reaches it.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 60;

	typedef struct packed {
		logic [cas_pkg::BITS_W-1:0]          clock_bits;
		logic                                new_bits;
		logic                                waiting;
		logic signed [cas_pkg::QCOUNT_W-1:0] quarter_ticks;
	} clock_out_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [cas_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [cas_pkg::CFG_W-1:0]     cfg_data  = '0;

	cas_item_if   item_ch ();
	cas_result_if result_ch ();

	cpu_clock_and_stepper i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Outputs the model has produced for accepted items, oldest first.
	clock_out_t due_outputs[$];

	int fail_count    = 0;
	int cycle_count   = 0;
	int stall_left    = 0;
	int results_taken = 0;
	int results_drawn = 0;
	// When set, neither side inserts gaps, so items arrive back to back.
	bit no_idling     = 1'b0;

	// ------------------------------------------------------------------------
	// Model of the block: a copy of the register file and of the clock state.
	// ------------------------------------------------------------------------
	logic                           cfg_manual;
	logic [cas_pkg::HZ_W-1:0]       cfg_hz;
	logic [cas_pkg::SLOWDOWN_W-1:0] cfg_slow;
	logic [cas_pkg::DEBOUNCE_W-1:0] cfg_debounce;

	logic                           started;
	logic [TIMER_W-1:0]             ms_elapsed;
	logic [cas_pkg::QCOUNT_W-1:0]   qcount;
	logic [cas_pkg::STEP_W-1:0]     step_num;
	logic                           btn_stable;
	logic                           btn_prev;
	logic [TIMER_W-1:0]             ms_since_change;
	logic [cas_pkg::BITS_W-1:0]     pattern;
	logic                           lamp;

	// Millisecond timers stop at their all-ones value instead of wrapping.
	function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
		return (&t) ? t : t + 1'b1;
	endfunction

	// A restart keeps the last pattern and the debounce timer; the button
	// state is reloaded from the mode that is set at that moment.
	function automatic void restart_clock();
		started    = 1'b0;
		ms_elapsed = '0;
		qcount     = '1;
		step_num   = '0;
		btn_stable = cfg_manual;
		btn_prev   = cfg_manual;
		lamp       = 1'b1;
	endfunction

	function automatic void reset_model();
		cfg_manual      = 1'b0;
		cfg_hz          = cas_pkg::CLOCK_HZ_RST;
		cfg_slow        = cas_pkg::SLOWDOWN_RST;
		cfg_debounce    = cas_pkg::DEBOUNCE_RST;
		ms_since_change = '0;
		pattern         = '0;
		restart_clock();
	endfunction

	// One quarter tick: the phase is the low two bits of the count, enable is
	// high on every phase but the idle one, set only on the set phase, and the
	// one-hot step moves on phase 0, running 1..6 and back to 1.
	function automatic void advance_quarter();
		logic [1:0]                 phase;
		logic [cas_pkg::BITS_W-1:0] steps;
		qcount = qcount + 1'b1;
		phase  = qcount[1:0];
		if (phase == cas_pkg::PHASE_STEP) begin
			step_num = (step_num >= cas_pkg::STEP_LAST) ? cas_pkg::STEP_FIRST
				: step_num + 1'b1;
		end
		steps = '0;
		if (step_num >= cas_pkg::STEP_FIRST && step_num <= cas_pkg::STEP_LAST) begin
			steps = 8'h01 << (8 - int'(step_num));
		end
		pattern = steps | {6'b0, phase != cas_pkg::PHASE_IDLE, phase == cas_pkg::PHASE_SET};
	endfunction

	// The button counts once it has been steady for more than the debounce
	// time; only a change to high is a press.
	function automatic logic button_press(input logic level);
		logic press;
		press = 1'b0;
		if (level != btn_prev) begin
			ms_since_change = '0;
		end
		if (ms_since_change > cfg_debounce && level != btn_stable) begin
			btn_stable = level;
			press      = level;
		end
		btn_prev = level;
		return press;
	endfunction

	function automatic clock_out_t predict_clock_out(input cas_pkg::op_t op,
		input logic level);
		int unsigned period_div;
		logic        fired;
		fired = 1'b0;
		if (op == cas_pkg::OP_RESTART) begin
			restart_clock();
		end else begin
			ms_elapsed      = sat_inc(ms_elapsed);
			ms_since_change = sat_inc(ms_since_change);
			if (!cfg_manual) begin
				// The first tick after a restart only turns the lamp off.
				if (!started) begin
					started = 1'b1;
					lamp    = 1'b0;
				end else begin
					// A zero slowdown or a rate that divides down to zero
					// leaves the automatic clock stopped.
					period_div = (cfg_slow != 0) ? 4 * (int'(cfg_hz) / int'(cfg_slow)) : 0;
					if (period_div != 0 && ms_elapsed >= 1000 / period_div) begin
						advance_quarter();
						ms_elapsed = '0;
						fired      = 1'b1;
					end
				end
			end else if (button_press(level)) begin
				advance_quarter();
				fired = 1'b1;
			end
		end
		return '{pattern, fired, lamp, qcount};
	endfunction

	// ------------------------------------------------------------------------
	// Item side. Payload and valid change only on the falling edge; the item
	// is taken at the first rising edge where the block is ready, and the
	// model is stepped at that moment with the registers then in force.
	// ------------------------------------------------------------------------
	task automatic send_item(input cas_pkg::op_t op, input logic level);
		int gap;
		gap = no_idling ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.op           <= op;
		item_ch.button_level <= level;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		due_outputs.push_back(predict_clock_out(op, level));
		@(negedge clk);
	endtask

	// Drops valid, waits for every outstanding result and then lets the
	// block's own latency pass, so that it is idle afterwards.
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (due_outputs.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write enable is left high between back-to-back writes and is lowered
	// once, after the last of them.
	task automatic write_reg(input cas_pkg::reg_index_t idx,
		input logic [cas_pkg::CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		case (idx)
			cas_pkg::REG_MANUAL_MODE: cfg_manual   = value[0];
			cas_pkg::REG_CLOCK_HZ:    cfg_hz       = value[cas_pkg::HZ_W-1:0];
			cas_pkg::REG_SLOWDOWN:    cfg_slow     = value[cas_pkg::SLOWDOWN_W-1:0];
			cas_pkg::REG_DEBOUNCE_MS: cfg_debounce = value[cas_pkg::DEBOUNCE_W-1:0];
		endcase
	endtask

	task automatic set_config(input logic manual, input logic [cas_pkg::HZ_W-1:0] hz,
		input logic [cas_pkg::SLOWDOWN_W-1:0] slow,
		input logic [cas_pkg::DEBOUNCE_W-1:0] deb);
		wait_idle();
		write_reg(cas_pkg::REG_MANUAL_MODE, cas_pkg::CFG_W'(manual));
		write_reg(cas_pkg::REG_CLOCK_HZ, cas_pkg::CFG_W'(hz));
		write_reg(cas_pkg::REG_SLOWDOWN, cas_pkg::CFG_W'(slow));
		write_reg(cas_pkg::REG_DEBOUNCE_MS, cas_pkg::CFG_W'(deb));
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Result side. Ready changes on the falling edge; after each transaction
	// the receiver draws how many cycles it holds ready low before the next.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (results_drawn != results_taken) begin
			results_drawn = results_taken;
			stall_left    = no_idling ? 0 : $urandom_range(0, 11);
		end
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left      = stall_left - 1;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		clock_out_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			results_taken <= results_taken + 1;
			if (due_outputs.size() == 0) begin
				$error("result transaction with no item waiting for it");
				fail_count++;
			end else begin
				want = due_outputs.pop_front();
				if (result_ch.clock_bits !== want.clock_bits) begin
					$error("clock_bits: expected %02h, got %02h",
						want.clock_bits, result_ch.clock_bits);
					fail_count++;
				end
				if (result_ch.new_bits !== want.new_bits) begin
					$error("new_bits: expected %0b, got %0b",
						want.new_bits, result_ch.new_bits);
					fail_count++;
				end
				if (result_ch.waiting !== want.waiting) begin
					$error("waiting: expected %0b, got %0b",
						want.waiting, result_ch.waiting);
					fail_count++;
				end
				if (result_ch.quarter_ticks !== want.quarter_ticks) begin
					$error("quarter_ticks: expected %0d, got %0d",
						want.quarter_ticks, result_ch.quarter_ticks);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: a handshake that never completes ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Directed tests.
	// ------------------------------------------------------------------------

	// Reset values: automatic mode at 1 Hz, so a quarter tick is 250 ms away.
	// The first tick only clears the lamp, and a restart turns it back on.
	task automatic test_auto_start();
		send_item(cas_pkg::OP_TICK, 1'b0);
		send_item(cas_pkg::OP_TICK, 1'b1);
		send_item(cas_pkg::OP_TICK, 1'b0);
		send_item(cas_pkg::OP_RESTART, 1'b1);
		send_item(cas_pkg::OP_TICK, 1'b0);
	endtask

	// At 1000 Hz the period divides down to zero ms, so every tick after the
	// first one fires and walks through all four phases.
	task automatic test_fast_auto();
		set_config(1'b0, 10'd1000, 8'd1, 16'd0);
		send_item(cas_pkg::OP_RESTART, 1'b0);
		repeat (6) send_item(cas_pkg::OP_TICK, 1'b1);
	endtask

	// A rate that truncates to zero and a zero slowdown both stop the clock.
	task automatic test_zero_divisor();
		set_config(1'b0, 10'd1, 8'd2, 16'd0);
		send_item(cas_pkg::OP_TICK, 1'b0);
		send_item(cas_pkg::OP_TICK, 1'b1);
		set_config(1'b0, 10'd1000, 8'd0, 16'd0);
		send_item(cas_pkg::OP_TICK, 1'b1);
		send_item(cas_pkg::OP_TICK, 1'b0);
	endtask

	// Manual mode with no debounce: the release counts on the second steady
	// tick, then a held press fires once. With the longest debounce time the
	// timer can never get past it, so nothing fires at all.
	task automatic test_manual_debounce();
		set_config(1'b1, 10'd1, 8'd1, 16'd0);
		send_item(cas_pkg::OP_RESTART, 1'b0);
		send_item(cas_pkg::OP_TICK, 1'b0);
		send_item(cas_pkg::OP_TICK, 1'b0);
		send_item(cas_pkg::OP_TICK, 1'b1);
		send_item(cas_pkg::OP_TICK, 1'b1);
		send_item(cas_pkg::OP_TICK, 1'b1);
		send_item(cas_pkg::OP_TICK, 1'b0);
		set_config(1'b1, 10'd1, 8'd1, 16'hFFFF);
		send_item(cas_pkg::OP_TICK, 1'b0);
		send_item(cas_pkg::OP_TICK, 1'b0);
		send_item(cas_pkg::OP_TICK, 1'b1);
		send_item(cas_pkg::OP_TICK, 1'b1);
	endtask

	// ------------------------------------------------------------------------
	// Random traffic, one register setting per phase. The first phases pin
	// the extreme settings; the rest mix extremes with rates fast enough that
	// quarter ticks fire within a phase. In manual mode the button is driven
	// as runs of steady level sized around the debounce time, so that presses
	// get through, with a share of raw noise and the odd restart.
	// ------------------------------------------------------------------------
	task automatic test_random_traffic();
		logic                           manual;
		logic [cas_pkg::HZ_W-1:0]       hz;
		logic [cas_pkg::SLOWDOWN_W-1:0] slow;
		logic [cas_pkg::DEBOUNCE_W-1:0] deb;
		logic                           level;
		int                             run_left;
		int                             run_max;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin manual = 1'b0; hz = 10'd1000; slow = 8'd1;   deb = 16'd0; end
				1: begin manual = 1'b1; hz = 10'd1023; slow = 8'd255; deb = 16'd0; end
				2: begin manual = 1'b0; hz = 10'd250;  slow = 8'd1;   deb = 16'hFFFF; end
				default: begin
					manual = 1'($urandom_range(0, 1));
					case ($urandom_range(0, 5))
						0: hz = 10'd1000;
						1: hz = 10'd1;
						2: hz = $urandom_range(0, 1) ? 10'd0 : 10'd1023;
						default: hz = cas_pkg::HZ_W'($urandom_range(100, 1000));
					endcase
					case ($urandom_range(0, 5))
						0: slow = 8'd255;
						1: slow = 8'd0;
						2: slow = cas_pkg::SLOWDOWN_W'($urandom_range(1, 255));
						default: slow = cas_pkg::SLOWDOWN_W'($urandom_range(1, 4));
					endcase
					case ($urandom_range(0, 7))
						0: deb = 16'd50;
						1: deb = 16'hFFFF;
						2: deb = 16'hFFFE;
						default: deb = cas_pkg::DEBOUNCE_W'($urandom_range(0, 6));
					endcase
				end
			endcase
			set_config(manual, hz, slow, deb);
			no_idling = ($urandom_range(0, 3) == 0);
			run_max   = (deb <= 8) ? int'(deb) + 3 : 11;
			level     = 1'($urandom_range(0, 1));
			run_left  = 1;
			if ($urandom_range(0, 1)) begin
				send_item(cas_pkg::OP_RESTART, level);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 31) == 0) begin
					send_item(cas_pkg::OP_RESTART, 1'($urandom_range(0, 1)));
				end else begin
					run_left--;
					if (run_left <= 0) begin
						level    = ~level;
						run_left = $urandom_range(1, run_max);
					end
					if (manual && $urandom_range(0, 7) != 0) begin
						send_item(cas_pkg::OP_TICK, level);
					end else begin
						send_item(cas_pkg::OP_TICK, 1'($urandom_range(0, 1)));
					end
				end
			end
			no_idling = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence of the run. Reset is applied once; the registers start at
	// their reset values, which the first test relies on.
	// ------------------------------------------------------------------------
	initial begin
		item_ch.valid        = 1'b0;
		item_ch.op           = cas_pkg::OP_TICK;
		item_ch.button_level = 1'b0;
		reset_model();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_auto_start();
		test_fast_auto();
		test_zero_divisor();
		test_manual_debounce();
		test_random_traffic();

		wait_idle();
		if (fail_count == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/cas_pkg.sv
sv/cas_if.sv
sv/cas_div.sv
sv/cas_step.sv
sv/cpu_clock_and_stepper.sv
sv/cas_chk.sv
tb/tb_top.sv
